// File: src/polygon_edge_scan_unit_macros.svh
// Assertion macros for the checker of the polygon edge scan unit
`ifndef POLYGON_EDGE_SCAN_UNIT_MACROS_SVH
`define POLYGON_EDGE_SCAN_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its trigger; expects clk and arst_n in scope.
`define PES_ASSERT_SAME(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("pes check failed");

// Check a consequence in the cycle after its trigger; expects clk and arst_n in scope.
`define PES_ASSERT_NEXT(label, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("pes check failed");

`endif

// File: src/pes_pkg.sv
// Package: types, codes and constants of the polygon edge scan unit
`timescale 1ns / 1ps

package pes_pkg;

	localparam int ROWS_DEFAULT      = 256;
	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int PRESTEP_BITS      = 16;

	localparam int S_TDATA_W = 176;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 2;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		STAT_SCANNED = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_READ    = 2'd2,
		STAT_CLIPPED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DSTART,
		ST_DIV,
		ST_MUL,
		ST_PRE,
		ST_WALK,
		ST_RDADDR,
		ST_RDDATA,
		ST_DONE
	} state_t;

	// Write and read strobes of the left and right edge tables
	typedef struct packed {
		logic we_left;
		logic we_right;
		logic re;
	} tbl_ctl_t;

endpackage

// File: src/pes_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
`timescale 1ns / 1ps

module pes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/pes_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pes_div #(
	parameter int NW = 50,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: src/polygon_edge_scan_unit.sv
// Polygon edge scan unit: slope divider, prestep, per-row edge table writer and table read
// Scan: after accept, prep, divider start, the serial slope division (skipped for a flat
//   edge), multiply and prestep, then one table write per covered row inside the table,
//   into the left or the right edge table as side selects.
// Empty edge: straight to the result; table read: address, then data; one item in flight at a time.
// Reset (arst_n low, asynchronous) clears the sequencer and the output valid; the
//   edge tables are not cleared and hold undefined data until written.
`timescale 1ns / 1ps

module polygon_edge_scan_unit #(
	parameter int ROWS      = pes_pkg::ROWS_DEFAULT,
	parameter int FRAC_BITS = pes_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata, from bit 0: top_x[31:0], top_y[63:32], bottom_x[95:64],
	// bottom_y[127:96], prestep_frac[143:128], top_row[152:144],
	// bottom_row[161:153], read_row[169:162], zero fill [175:170]
	input  logic [pes_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser, from bit 0: op[0], side[1]
	input  logic [pes_pkg::S_TUSER_W-1:0] s_tuser,
	// Result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata, from bit 0: left_x[31:0], right_x[63:32]
	output logic [pes_pkg::M_TDATA_W-1:0] m_tdata,
	// m_tuser, from bit 0: status[1:0]
	output logic [pes_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int AW = $clog2(ROWS);
	// Numerator of the slope division: 33-bit |dx| shifted by FRAC_BITS plus a rounding carry
	localparam int NW = 34 + FRAC_BITS;
	localparam int DW = 33;
	// Prestep product: unsigned 0.16 fraction (kept positive in 17 bits) times signed slope
	localparam int PW = pes_pkg::PRESTEP_BITS + 33;
	localparam logic [31:0] ROWS_W = 32'(ROWS);
	localparam logic [31:0] HALF   = 32'(1 << (FRAC_BITS - 1));
	localparam logic [PW-1:0] PRE_RND = PW'(1 << (pes_pkg::PRESTEP_BITS - 1));

	pes_pkg::state_t  state_q, state_d;
	pes_pkg::tbl_ctl_t tbl;

	// Unpacked input transaction fields
	logic [31:0] in_top_x, in_top_y, in_bot_x, in_bot_y;
	logic [15:0] in_pre;
	logic [8:0]  in_trow, in_brow;
	logic [7:0]  in_rrow;
	logic        in_op, in_side;

	assign in_top_x = s_tdata[31:0];
	assign in_top_y = s_tdata[63:32];
	assign in_bot_x = s_tdata[95:64];
	assign in_bot_y = s_tdata[127:96];
	assign in_pre   = s_tdata[143:128];
	assign in_trow  = s_tdata[152:144];
	assign in_brow  = s_tdata[161:153];
	assign in_rrow  = s_tdata[169:162];
	assign in_op    = s_tuser[0];
	assign in_side  = s_tuser[1];

	// Held transaction and working registers
	logic [31:0]   tx_q;
	logic [32:0]   dx_q, dy_q;
	logic [32:0]   ux_q, uy_q;
	logic          neg_q;
	logic [31:0]   txh_q;
	logic [15:0]   pre_q;
	logic [8:0]    trow_q, brow_q, row_q;
	logic [7:0]    rrow_q;
	logic          side_q;
	logic [31:0]   slope_q;
	logic [PW-1:0] prod_q;
	logic [31:0]   x_q;

	// Pending result, moved to the output register when it is free
	pes_pkg::status_t res_status_q;
	logic [31:0]      res_left_q, res_right_q;

	logic          m_tvalid_q;
	logic [1:0]    m_status_q;
	logic [63:0]   m_data_q;

	// Divider hookup
	logic          div_start;
	logic          div_done;
	logic [NW-1:0] div_num;
	logic [NW-1:0] div_quot;

	// Table ports
	logic [31:0]   left_rdata, right_rdata;

	// Derived conditions
	logic          empty_edge;
	logic          row_in_span;
	logic          row_in_table;
	logic          rrow_in_table;
	logic          out_load;
	logic          pos_over, neg_over;
	logic [31:0]   slope_sat;
	logic [31:0]   slope_mag;
	logic [PW-1:0] pre_rnd;

	assign empty_edge    = (in_brow <= in_trow);
	assign row_in_span   = (row_q < brow_q);
	assign row_in_table  = (32'(row_q) < ROWS_W);
	assign rrow_in_table = (32'(rrow_q) < ROWS_W);

	// Round-to-nearest numerator: (|dx| << FRAC_BITS) + |dy| / 2
	assign div_num = {1'b0, ux_q, {FRAC_BITS{1'b0}}} + {{(NW - 32){1'b0}}, uy_q[32:1]};

	// Clamp the quotient to the signed 32-bit range, then apply the sign
	assign pos_over  = |div_quot[NW-1:31];
	assign neg_over  = (|div_quot[NW-1:32]) || (div_quot[31] && (|div_quot[30:0]));
	assign slope_mag = neg_over ? 32'h8000_0000 : div_quot[31:0];
	assign slope_sat = neg_q ? (32'd0 - slope_mag) :
		(pos_over ? 32'h7FFF_FFFF : div_quot[31:0]);

	// Prestep increment, rounded half up: floor((pre * slope + 2^15) / 2^16)
	assign pre_rnd = prod_q + PRE_RND;

	pes_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (uy_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	pes_ram #(
		.WIDTH(32),
		.DEPTH(ROWS)
	) u_left_tbl (
		.clk  (clk),
		.we   (tbl.we_left),
		.waddr(AW'(row_q)),
		.wdata(x_q),
		.re   (tbl.re),
		.raddr(AW'(rrow_q)),
		.rdata(left_rdata)
	);

	pes_ram #(
		.WIDTH(32),
		.DEPTH(ROWS)
	) u_right_tbl (
		.clk  (clk),
		.we   (tbl.we_right),
		.waddr(AW'(row_q)),
		.wdata(x_q),
		.re   (tbl.re),
		.raddr(AW'(rrow_q)),
		.rdata(right_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pes_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (in_op == pes_pkg::OP_READ) begin
						state_d = pes_pkg::ST_RDADDR;
					end else if (empty_edge) begin
						state_d = pes_pkg::ST_DONE;
					end else begin
						state_d = pes_pkg::ST_PREP;
					end
				end
			end
			pes_pkg::ST_PREP: begin
				// A flat edge skips the division: slope is zero
				state_d = (dy_q == '0) ? pes_pkg::ST_MUL : pes_pkg::ST_DSTART;
			end
			pes_pkg::ST_DSTART: state_d = pes_pkg::ST_DIV;
			pes_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = pes_pkg::ST_MUL;
				end
			end
			pes_pkg::ST_MUL:    state_d = pes_pkg::ST_PRE;
			pes_pkg::ST_PRE:    state_d = pes_pkg::ST_WALK;
			pes_pkg::ST_WALK: begin
				// Stop at the span end or at the first row past the table
				if (!row_in_span || !row_in_table) begin
					state_d = pes_pkg::ST_DONE;
				end
			end
			pes_pkg::ST_RDADDR: state_d = pes_pkg::ST_RDDATA;
			pes_pkg::ST_RDDATA: state_d = pes_pkg::ST_DONE;
			pes_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = pes_pkg::ST_IDLE;
				end
			end
			default: state_d = pes_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		s_tready     = 1'b0;
		div_start    = 1'b0;
		tbl.we_left  = 1'b0;
		tbl.we_right = 1'b0;
		tbl.re       = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			pes_pkg::ST_IDLE:   s_tready  = 1'b1;
			pes_pkg::ST_DSTART: div_start = 1'b1;
			pes_pkg::ST_WALK: begin
				tbl.we_left  = row_in_span && row_in_table && !side_q;
				tbl.we_right = row_in_span && row_in_table && side_q;
			end
			pes_pkg::ST_RDADDR: tbl.re = 1'b1;
			pes_pkg::ST_DONE:   out_load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pes_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pes_pkg::ST_IDLE: begin
				// Latch the transaction; form exact 33-bit differences
				tx_q        <= in_top_x;
				dx_q        <= {in_bot_x[31], in_bot_x} - {in_top_x[31], in_top_x};
				dy_q        <= {in_bot_y[31], in_bot_y} - {in_top_y[31], in_top_y};
				pre_q       <= in_pre;
				trow_q      <= in_trow;
				brow_q      <= in_brow;
				rrow_q      <= in_rrow;
				side_q      <= in_side;
				res_status_q <= pes_pkg::STAT_EMPTY;
				res_left_q  <= '0;
				res_right_q <= '0;
			end
			pes_pkg::ST_PREP: begin
				ux_q    <= dx_q[32] ? (33'd0 - dx_q) : dx_q;
				uy_q    <= dy_q[32] ? (33'd0 - dy_q) : dy_q;
				neg_q   <= dx_q[32] ^ dy_q[32];
				txh_q   <= tx_q + HALF;
				slope_q <= '0;
			end
			pes_pkg::ST_DIV: begin
				if (div_done) begin
					slope_q <= slope_sat;
				end
			end
			pes_pkg::ST_MUL: begin
				prod_q <= PW'($signed({1'b0, pre_q}) * $signed(slope_q));
			end
			pes_pkg::ST_PRE: begin
				x_q   <= txh_q + pre_rnd[pes_pkg::PRESTEP_BITS +: 32];
				row_q <= trow_q;
			end
			pes_pkg::ST_WALK: begin
				if (row_in_span && row_in_table) begin
					// Advance one scanline, wrapping x at 32 bits
					x_q   <= x_q + slope_q;
					row_q <= row_q + 1'b1;
				end else begin
					res_status_q <= row_in_span ? pes_pkg::STAT_CLIPPED : pes_pkg::STAT_SCANNED;
					res_left_q   <= '0;
					res_right_q  <= '0;
				end
			end
			pes_pkg::ST_RDDATA: begin
				res_status_q <= pes_pkg::STAT_READ;
				res_left_q   <= rrow_in_table ? left_rdata : 32'd0;
				res_right_q  <= rrow_in_table ? right_rdata : 32'd0;
			end
			pes_pkg::ST_DONE: begin
				if (out_load) begin
					m_status_q <= res_status_q;
					m_data_q   <= {res_right_q, res_left_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Hold status with its payload in the output register while the result waits
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;

endmodule

// File: src/pes_checker.sv
// Port-level checker of the polygon edge scan unit, bound to the top level
`timescale 1ns / 1ps
`include "polygon_edge_scan_unit_macros.svh"

module pes_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [pes_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [pes_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pes_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [pes_pkg::M_TUSER_W-1:0] m_tuser
);

	logic s_acc;
	logic m_stall;
	logic scan_result;
	logic read_acc;

	assign s_acc       = s_tvalid && s_tready;
	assign m_stall     = m_tvalid && !m_tready;
	assign scan_result = m_tvalid && (m_tuser != pes_pkg::STAT_READ);
	assign read_acc    = s_acc && (s_tuser[0] == pes_pkg::OP_READ) && (s_tdata[175:170] == 6'd0);

	// A stalled result transaction holds its payload
	`PES_ASSERT_NEXT(a_out_hold, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// One item at a time: input closes right after an accepted transaction
	`PES_ASSERT_NEXT(a_one_in_flight, s_acc, !s_tready)
	// A new result appears only after a busy cycle on the input side
	`PES_ASSERT_SAME(a_result_after_work, $rose(m_tvalid), !$past(s_tready))
	// Scan results carry zero x fields
	`PES_ASSERT_SAME(a_scan_zero_fields, scan_result, m_tdata == '0)
	// A read transaction keeps the input closed while the table is read
	`PES_ASSERT_NEXT(a_read_busy, read_acc, !s_tready && !m_tvalid || !s_tready)

endmodule

bind polygon_edge_scan_unit pes_checker u_pes_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
